/* hw/rtl/i2cms_pkg.sv */
// i2cms_pkg: shared types and constants for the i2c master transaction sequencer
// holds the command/event beat, result beat, sequencer state and status codes
// no dependencies
`timescale 1ns / 1ps

package i2cms_pkg;

  // action codes of an input beat
  localparam logic ACT_CMD   = 1'b0;
  localparam logic ACT_EVENT = 1'b1;

  // engine status codes, low three bits masked off
  localparam logic [7:0] ST_MASK          = 8'hf8;
  localparam logic [7:0] ST_START         = 8'h08;
  localparam logic [7:0] ST_RSTART        = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK     = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK    = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK    = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK   = 8'h30;
  localparam logic [7:0] ST_ARB_LOST      = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK     = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK    = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK    = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK   = 8'h58;

  // control action handed to the byte engine
  typedef enum logic [2:0] {
    CTL_ACK    = 3'd0,
    CTL_NACK   = 3'd1,
    CTL_STOP   = 3'd2,
    CTL_RSTART = 3'd3,
    CTL_START  = 3'd4,
    CTL_RESUME = 3'd5
  } ctl_t;

  // latched error code
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_ADDR_NACK = 2'd1,
    ERR_DATA_NACK = 2'd2,
    ERR_ARB_LOST  = 2'd3
  } err_t;

  // one input beat
  typedef struct packed {
    logic        action;
    logic [6:0]  target_address;
    logic        read_request;
    logic [15:0] byte_count;
    logic        stop_at_end;
    logic [7:0]  bus_status;
    logic [7:0]  received_byte;
    logic [7:0]  tx_data;
  } item_t;

  // one result beat
  typedef struct packed {
    ctl_t       control;
    logic [7:0] data_out;
    logic       data_out_valid;
    logic       tx_taken;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       busy_res;
    err_t       error_code;
  } result_t;

  // sequencer state
  typedef struct packed {
    logic [15:0] remaining;
    logic [7:0]  address_byte;
    logic        busy_flag;
    logic        stop_flag;
    logic        restart_pending;
    err_t        error_state;
  } seq_state_t;

endpackage

/* hw/rtl/i2cms_if.sv */
// i2cms_if: valid/ready channel interfaces of the i2c master transaction sequencer
// i2cms_in_if carries command and status beats, i2cms_out_if carries result beats
// no dependencies
`timescale 1ns / 1ps

interface i2cms_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [6:0]  target_address;
  logic        read_request;
  logic [15:0] byte_count;
  logic        stop_at_end;
  logic [7:0]  bus_status;
  logic [7:0]  received_byte;
  logic [7:0]  tx_data;

  modport source (
    output valid, action, target_address, read_request, byte_count, stop_at_end,
           bus_status, received_byte, tx_data,
    input  ready
  );
  modport sink (
    input  valid, action, target_address, read_request, byte_count, stop_at_end,
           bus_status, received_byte, tx_data,
    output ready
  );
endinterface

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] control;
  logic [7:0] data_out;
  logic       data_out_valid;
  logic       tx_taken;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       busy_res;
  logic [1:0] error_code;

  modport source (
    output valid, control, data_out, data_out_valid, tx_taken, rx_valid, rx_byte,
           busy_res, error_code,
    input  ready
  );
  modport sink (
    input  valid, control, data_out, data_out_valid, tx_taken, rx_valid, rx_byte,
           busy_res, error_code,
    output ready
  );
endinterface

/* hw/rtl/i2cms_decide.sv */
// i2cms_decide: combinational decision for one beat of the transaction sequencer
// maps current state and one command or status beat to the result and next state
// depends on i2cms_pkg
`timescale 1ns / 1ps

module i2cms_decide (
  input  i2cms_pkg::item_t      item,
  input  i2cms_pkg::seq_state_t state,
  output i2cms_pkg::seq_state_t state_nxt,
  output i2cms_pkg::result_t    res
);
  import i2cms_pkg::*;

  logic [7:0]  status;
  logic [15:0] cmd_count;
  logic [15:0] rd_remaining;
  ctl_t        end_ctl;
  ctl_t        rd_ctl;
  seq_state_t  nxt;
  result_t     r;

  // masked status, zero-length read becomes one byte
  assign status    = item.bus_status & ST_MASK;
  assign cmd_count = (item.read_request && (item.byte_count == 16'd0)) ? 16'd1
                                                                       : item.byte_count;

  // end of transfer: stop or repeated start
  assign end_ctl = state.stop_flag ? CTL_STOP : CTL_RSTART;

  // read continuation: count down, nack on the last byte
  assign rd_remaining = (state.remaining != 16'd0) ? state.remaining - 16'd1 : 16'd0;
  assign rd_ctl       = (rd_remaining != 16'd0) ? CTL_ACK : CTL_NACK;

  // decision
  always_comb begin
    nxt              = state;
    r.control        = CTL_ACK;
    r.data_out       = 8'd0;
    r.data_out_valid = 1'b0;
    r.tx_taken       = 1'b0;
    r.rx_valid       = 1'b0;
    r.rx_byte        = 8'd0;
    if (item.action == ACT_CMD) begin
      nxt.address_byte = {item.target_address, item.read_request};
      nxt.remaining    = cmd_count;
      nxt.stop_flag    = item.stop_at_end;
      nxt.busy_flag    = 1'b1;
      nxt.error_state  = ERR_NONE;
      if (state.restart_pending) begin
        nxt.restart_pending = 1'b0;
        r.control           = CTL_RESUME;
      end else begin
        r.control = CTL_START;
      end
    end else if (state.busy_flag) begin
      unique case (status) inside
        ST_START, ST_RSTART: begin
          r.data_out       = state.address_byte;
          r.data_out_valid = 1'b1;
        end
        ST_SLA_W_ACK, ST_DATA_W_ACK: begin
          if (state.remaining != 16'd0) begin
            nxt.remaining    = state.remaining - 16'd1;
            r.data_out       = item.tx_data;
            r.data_out_valid = 1'b1;
            r.tx_taken       = 1'b1;
          end else begin
            r.control           = end_ctl;
            nxt.restart_pending = state.restart_pending | ~state.stop_flag;
            nxt.busy_flag       = 1'b0;
          end
        end
        ST_SLA_W_NACK, ST_SLA_R_NACK: begin
          nxt.error_state     = ERR_ADDR_NACK;
          r.control           = end_ctl;
          nxt.restart_pending = state.restart_pending | ~state.stop_flag;
          nxt.busy_flag       = 1'b0;
        end
        ST_DATA_W_NACK: begin
          nxt.error_state     = ERR_DATA_NACK;
          r.control           = end_ctl;
          nxt.restart_pending = state.restart_pending | ~state.stop_flag;
          nxt.busy_flag       = 1'b0;
        end
        ST_ARB_LOST: begin
          nxt.error_state = ERR_ARB_LOST;
          nxt.busy_flag   = 1'b0;
          r.control       = CTL_STOP;
        end
        ST_DATA_R_ACK: begin
          r.rx_valid    = 1'b1;
          r.rx_byte     = item.received_byte;
          nxt.remaining = rd_remaining;
          r.control     = rd_ctl;
        end
        ST_SLA_R_ACK: begin
          nxt.remaining = rd_remaining;
          r.control     = rd_ctl;
        end
        ST_DATA_R_NACK: begin
          r.rx_valid          = 1'b1;
          r.rx_byte           = item.received_byte;
          r.control           = end_ctl;
          nxt.restart_pending = state.restart_pending | ~state.stop_flag;
          nxt.busy_flag       = 1'b0;
        end
        default: begin
          r.control = CTL_ACK;
        end
      endcase
    end
    r.busy_res   = nxt.busy_flag;
    r.error_code = nxt.error_state;
  end

  assign state_nxt = nxt;
  assign res       = r;

endmodule

/* hw/rtl/i2c_master_transaction_sequencer.sv */
// i2c_master_transaction_sequencer: top level of the master-side i2c sequencer
// input register, decision logic, result register and sequencer state
// depends on i2cms_pkg, i2cms_if (i2cms_in_if, i2cms_out_if) and i2cms_decide
`timescale 1ns / 1ps

// Usage
//   in_ch  : one beat is either a start command (action 0: address, read/write,
//            byte count, stop choice) or a bus status event from the byte engine
//            (action 1: status, received byte, next transmit byte)
//   out_ch : exactly one result beat per input beat, in order: control action,
//            byte to load, transmit-consumed flag, received byte, busy, error
// A beat accepted from in_ch sits in the input register; once the result register
// is empty or being drained, its decision lands in the result register together
// with the sequencer state update, and out_ch.valid is then high.
// Throughput is one beat per cycle; the two register stages pass beats along
// as long as the result register is empty or being drained in that cycle.
// When the receiver stalls, the result beat holds, the input register fills
// and in_ch.ready drops until out_ch.ready returns; nothing is lost.
// Reset clears both valid bits and the sequencer state (idle, no error, no
// pending repeated start, count and address byte zero).
module i2c_master_transaction_sequencer (
  input logic      clk,
  input logic      rst_n,
  i2cms_in_if.sink    in_ch,
  i2cms_out_if.source out_ch
);
  import i2cms_pkg::*;

  logic       s1_valid_r;
  item_t      s1_item_r;
  logic       out_valid_r;
  result_t    out_res_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  result_t    res;
  item_t      in_item;
  logic       s1_advance;
  logic       in_fire;

  // handshake
  assign s1_advance  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // pack the input beat
  assign in_item.action         = in_ch.action;
  assign in_item.target_address = in_ch.target_address;
  assign in_item.read_request   = in_ch.read_request;
  assign in_item.byte_count     = in_ch.byte_count;
  assign in_item.stop_at_end    = in_ch.stop_at_end;
  assign in_item.bus_status     = in_ch.bus_status;
  assign in_item.received_byte  = in_ch.received_byte;
  assign in_item.tx_data        = in_ch.tx_data;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
  end

  // decision logic
  i2cms_decide u_decide (
    .item      (s1_item_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .res       (res)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_res_r <= res;
    end
  end

  // result beat
  assign out_ch.valid          = out_valid_r;
  assign out_ch.control        = out_res_r.control;
  assign out_ch.data_out       = out_res_r.data_out;
  assign out_ch.data_out_valid = out_res_r.data_out_valid;
  assign out_ch.tx_taken       = out_res_r.tx_taken;
  assign out_ch.rx_valid       = out_res_r.rx_valid;
  assign out_ch.rx_byte        = out_res_r.rx_byte;
  assign out_ch.busy_res       = out_res_r.busy_res;
  assign out_ch.error_code     = out_res_r.error_code;

endmodule
